// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for the concurrent checks of the rhythm matcher.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, switched off while in reset.
`define KRM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the following cycle.
`define KRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/krm_pkg.sv -----
// ---------------------------------------------------------------------------
// krm_pkg
// Types and constants shared by the knock rhythm matcher modules.
// ---------------------------------------------------------------------------
package krm_pkg;

	localparam int PATTERN_LENGTH = 15;
	localparam int SAMPLE_W       = 10;
	localparam int INTERVAL_W     = 8;
	localparam int SPT_W          = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int IN_TDATA_W     = 16;
	localparam int OUT_TDATA_W    = 16;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_THRESHOLD   = 3'd0,
		REG_MIN_GAP_TICKS    = 3'd1,
		REG_MATCH_TOLERANCE  = 3'd2,
		REG_SAMPLES_PER_TICK = 3'd3,
		REG_PATTERN_FIRST    = 3'd4,
		REG_PATTERN_REST     = 3'd5
	} krm_reg_idx_t;

	localparam logic [SAMPLE_W-1:0]   RISE_THRESHOLD_RST   = 10'd20;
	localparam logic [INTERVAL_W-1:0] MIN_GAP_TICKS_RST    = 8'd5;
	localparam logic [INTERVAL_W-1:0] MATCH_TOLERANCE_RST  = 8'd10;
	localparam logic [SPT_W-1:0]      SAMPLES_PER_TICK_RST = 6'd50;
	localparam logic [63:0]           PATTERN_FIRST_RST    = 64'd1452499013228303400;
	localparam logic [55:0]           PATTERN_REST_RST     = 56'd11303152005949480;

	localparam logic [INTERVAL_W-1:0] TICK_MAX = '1;

	// Timing settings seen by the knock detector.
	typedef struct packed {
		logic [SAMPLE_W-1:0]   rise_threshold;
		logic [INTERVAL_W-1:0] min_gap_ticks;
		logic [SPT_W-1:0]      samples_per_tick;
	} krm_timing_cfg_t;

	// Control broadcast to every cell of the interval row.
	typedef struct packed {
		logic                  shift;
		logic                  clear;
		logic [INTERVAL_W-1:0] tolerance;
	} krm_cell_ctrl_t;

endpackage

// ----- rtl/krm_front.sv -----
// ---------------------------------------------------------------------------
// krm_front
// Knock detector and tick timer: judges each sample and counts ticks.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module krm_front
	import krm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [SAMPLE_W-1:0]   sample,
	input  krm_timing_cfg_t       cfg,
	output logic                  knock,
	output logic [INTERVAL_W-1:0] interval
);

	logic [SAMPLE_W-1:0]   prev_q;
	logic [INTERVAL_W-1:0] tick_q;
	logic [SPT_W-1:0]      sit_q;

	logic [SAMPLE_W-1:0]   rise;
	logic [SPT_W-1:0]      sit_inc;
	logic                  tick_done;
	logic [INTERVAL_W-1:0] tick_base;
	logic [INTERVAL_W-1:0] tick_next;

	assign rise     = sample - prev_q;
	assign knock    = (sample > prev_q) && (rise > cfg.rise_threshold)
		&& (tick_q > cfg.min_gap_ticks);
	assign interval = tick_q;

	// A zero setting counts as one sample per tick, since the wrapped count
	// is always at or past it.
	assign sit_inc   = sit_q + SPT_W'(1);
	assign tick_done = (sit_inc >= cfg.samples_per_tick) || (sit_inc == '0);
	assign tick_base = knock ? '0 : tick_q;

	always_comb begin
		tick_next = tick_base;
		if (tick_done && (tick_base != TICK_MAX)) begin
			tick_next = tick_base + INTERVAL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			tick_q <= '0;
			sit_q  <= '0;
		end else if (fire) begin
			prev_q <= sample;
			tick_q <= tick_next;
			sit_q  <= tick_done ? '0 : sit_inc;
		end
	end

	`KRM_ASSERT_NEXT(a_tick_restarts, fire && knock, tick_q <= INTERVAL_W'(1), "tick count not restarted after knock")

endmodule

// ----- rtl/krm_cell.sv -----
// ---------------------------------------------------------------------------
// krm_cell
// One interval slot of the row; checks the value it will hold against its
// expected interval.
// ---------------------------------------------------------------------------
module krm_cell
	import krm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  krm_cell_ctrl_t        ctrl,
	input  logic [INTERVAL_W-1:0] din,
	input  logic [INTERVAL_W-1:0] expected,
	output logic [INTERVAL_W-1:0] q,
	output logic                  ok
);

	logic [INTERVAL_W-1:0] val_q;
	logic [INTERVAL_W-1:0] nxt;
	logic [INTERVAL_W-1:0] diff;

	assign nxt  = ctrl.shift ? din : val_q;
	assign diff = (nxt >= expected) ? (nxt - expected) : (expected - nxt);
	assign ok   = (diff <= ctrl.tolerance);
	assign q    = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctrl.clear) begin
			val_q <= '0;
		end else if (ctrl.shift) begin
			val_q <= din;
		end
	end

endmodule

// ----- rtl/knock_rhythm_matcher.sv -----
// ---------------------------------------------------------------------------
// knock_rhythm_matcher
// Secret-knock detector: finds knocks in a sound sample stream and checks
// the rhythm of the last fifteen intervals against a programmed pattern.
// ---------------------------------------------------------------------------
// Every sample item yields exactly one result item in the cycle after it
// is taken, and the block takes one sample per clock cycle as long as the
// result register is empty or being drained in the same cycle. The rate is
// set by the loop through the knock detector, the tick timer
// and the row of fifteen interval cells: the decision for one sample feeds
// the tick count that judges the next. The cells form a shift row, oldest
// interval in cell 0 and newest in the last cell, so the row always reads
// oldest first; on a knock every cell takes its neighbor's value and the
// new interval enters at the end. Each cell compares the value it is about
// to hold with its own expected interval, and when all agree within the
// tolerance on a knock, the whole row is cleared and unlock is raised.
// Configuration registers are written through a plain write port and
// should only change while no item is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module knock_rhythm_matcher
	import krm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	// Sample stream in.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] sample, [15:10] zero

	// Result stream out.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] knock_seen, [1] unlock,
	                                          // [9:2] knock_interval, [15:10] zero

	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers.
	logic [SAMPLE_W-1:0]   rise_threshold_q;
	logic [INTERVAL_W-1:0] min_gap_ticks_q;
	logic [INTERVAL_W-1:0] match_tolerance_q;
	logic [SPT_W-1:0]      samples_per_tick_q;
	logic [63:0]           pattern_first_q;
	logic [55:0]           pattern_rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_threshold_q   <= RISE_THRESHOLD_RST;
			min_gap_ticks_q    <= MIN_GAP_TICKS_RST;
			match_tolerance_q  <= MATCH_TOLERANCE_RST;
			samples_per_tick_q <= SAMPLES_PER_TICK_RST;
			pattern_first_q    <= PATTERN_FIRST_RST;
			pattern_rest_q     <= PATTERN_REST_RST;
		end else if (cfg_we) begin
			case (krm_reg_idx_t'(cfg_index))
				REG_RISE_THRESHOLD:   rise_threshold_q   <= cfg_data[SAMPLE_W-1:0];
				REG_MIN_GAP_TICKS:    min_gap_ticks_q    <= cfg_data[INTERVAL_W-1:0];
				REG_MATCH_TOLERANCE:  match_tolerance_q  <= cfg_data[INTERVAL_W-1:0];
				REG_SAMPLES_PER_TICK: samples_per_tick_q <= cfg_data[SPT_W-1:0];
				REG_PATTERN_FIRST:    pattern_first_q    <= cfg_data;
				REG_PATTERN_REST:     pattern_rest_q     <= cfg_data[55:0];
				default: begin
				end
			endcase
		end
	end

	// An item moves in whenever the result register is free or emptying.
	logic out_valid_q;
	logic fire;

	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	// Knock detection and tick timing.
	krm_timing_cfg_t       timing_cfg;
	logic                  knock;
	logic [INTERVAL_W-1:0] interval;

	assign timing_cfg.rise_threshold   = rise_threshold_q;
	assign timing_cfg.min_gap_ticks    = min_gap_ticks_q;
	assign timing_cfg.samples_per_tick = samples_per_tick_q;

	krm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.sample   (s_tdata[SAMPLE_W-1:0]),
		.cfg      (timing_cfg),
		.knock    (knock),
		.interval (interval)
	);

	// Row of interval cells. The pattern registers are joined so that
	// expected interval k sits in byte k.
	logic [119:0]              pattern_all;
	logic [INTERVAL_W-1:0]     cell_q [PATTERN_LENGTH];
	logic [PATTERN_LENGTH-1:0] cell_ok;
	logic                      match;
	krm_cell_ctrl_t            cell_ctrl;

	assign pattern_all = {pattern_rest_q, pattern_first_q};
	assign match       = &cell_ok;

	assign cell_ctrl.shift     = fire && knock;
	assign cell_ctrl.clear     = fire && knock && match;
	assign cell_ctrl.tolerance = match_tolerance_q;

	for (genvar k = 0; k < PATTERN_LENGTH; k++) begin : g_cell
		logic [INTERVAL_W-1:0] din;

		if (k == PATTERN_LENGTH - 1) begin : g_tail
			assign din = interval;
		end else begin : g_body
			assign din = cell_q[k+1];
		end

		krm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.din      (din),
			.expected (pattern_all[k*INTERVAL_W +: INTERVAL_W]),
			.q        (cell_q[k]),
			.ok       (cell_ok[k])
		);
	end

	// Result register. The interval field reads zero when there was no knock.
	logic [OUT_TDATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {6'd0, (knock ? interval : INTERVAL_W'(0)),
				cell_ctrl.clear, knock};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`KRM_ASSERT_NEXT(a_newest_interval, fire && knock && !match, cell_q[PATTERN_LENGTH-1] == $past(interval), "newest cell does not hold the knock interval")
	`KRM_ASSERT_NEXT(a_row_cleared, cell_ctrl.clear, cell_q[0] == '0 && cell_q[PATTERN_LENGTH-1] == '0, "interval row not cleared after unlock")
	`KRM_ASSERT(a_unlock_needs_knock, !m_tvalid || !m_tdata[1] || m_tdata[0], "unlock reported without a knock")

endmodule

// ----- tb/tb_knock_rhythm_matcher.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_knock_rhythm_matcher
// Self-checking bench for the knock rhythm matcher. A short list of hand-made
// samples and register writes comes first. Random phases follow: knock
// rhythms aimed at a programmed pattern, plain noise with extreme register
// settings, and one long quiet stretch that saturates the tick count. Every
// result is compared with a hand-written one or a cycle-free detector model.
// ---------------------------------------------------------------------------
module tb_knock_rhythm_matcher;
	import krm_pkg::*;

	typedef struct packed {
		logic [INTERVAL_W-1:0] knock_interval;
		logic                  unlock;
		logic                  knock_seen;
	} knock_result_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		krm_reg_idx_t          reg_idx;
		logic [CFG_DATA_W-1:0] value;     // register value, or the sample in the low bits
		bit                    typed;     // want holds a hand-written result
		knock_result_t         want;
	} stim_row_t;

	localparam knock_result_t NO_KNOCK = '0;
	localparam logic [CFG_DATA_W-1:0] ALL_ONES = '1;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	knock_rhythm_matcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Detector model: settings and state.
	logic [SAMPLE_W-1:0]   rise_limit;
	logic [INTERVAL_W-1:0] gap_limit;
	logic [INTERVAL_W-1:0] tolerance;
	logic [SPT_W-1:0]      tick_len;
	logic [63:0]           rhythm_lo;
	logic [55:0]           rhythm_hi;
	logic [SAMPLE_W-1:0]   last_sample;
	logic [INTERVAL_W-1:0] ticks;
	logic [SPT_W-1:0]      tick_phase;
	logic [INTERVAL_W-1:0] intervals [PATTERN_LENGTH];
	int                    next_slot;

	knock_result_t pending_results[$];
	stim_row_t     directed_rows[$];
	int            error_count = 0;
	int            items_sent  = 0;
	int            gap_pct     = 0;
	int            stall_pct   = 0;

	function automatic int idle_length();
		return ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
	endfunction

	function automatic logic [INTERVAL_W-1:0] rhythm_at(int k);
		return (k < 8) ? rhythm_lo[8*k +: 8] : rhythm_hi[8*(k-8) +: 8];
	endfunction

	// Judges one sample and moves the model state on by one item.
	function automatic knock_result_t advance_detector(logic [SAMPLE_W-1:0] s);
		knock_result_t r;
		int            slot;
		int            pos;
		int            diff;
		bit            hit;
		r = NO_KNOCK;
		if (s > last_sample && int'(s) - int'(last_sample) > int'(rise_limit) &&
				ticks > gap_limit) begin
			slot = (next_slot >= PATTERN_LENGTH) ? 0 : next_slot;
			r.knock_seen     = 1'b1;
			r.knock_interval = ticks;
			intervals[slot]  = ticks;
			slot      = (slot + 1 >= PATTERN_LENGTH) ? 0 : slot + 1;
			next_slot = slot;
			// The ring is read oldest first, starting at the next slot to be written.
			hit = 1'b1;
			for (int k = 0; k < PATTERN_LENGTH; k++) begin
				pos  = (slot + k) % PATTERN_LENGTH;
				diff = int'(intervals[pos]) - int'(rhythm_at(k));
				if (diff < 0)
					diff = -diff;
				if (diff > int'(tolerance))
					hit = 1'b0;
			end
			if (hit) begin
				r.unlock = 1'b1;
				foreach (intervals[i])
					intervals[i] = '0;
			end
			ticks = '0;
		end
		last_sample = s;
		tick_phase  = tick_phase + 1'b1;
		if (tick_phase >= tick_len || tick_phase == '0) begin
			tick_phase = '0;
			if (ticks != TICK_MAX)
				ticks = ticks + 1'b1;
		end
		return r;
	endfunction

	// Offers one sample after an optional gap and records what it must produce.
	task automatic push_sample(input logic [SAMPLE_W-1:0] value, input bit typed = 1'b0,
			input knock_result_t want = NO_KNOCK);
		int            gap;
		knock_result_t got;
		gap = (gap_pct != 0 && $urandom_range(99) < gap_pct) ? idle_length() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, value};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		got = advance_detector(value);
		pending_results.push_back(typed ? want : got);
	endtask

	// Holds the sender back until every pending result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input krm_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RISE_THRESHOLD:   rise_limit = value[SAMPLE_W-1:0];
			REG_MIN_GAP_TICKS:    gap_limit  = value[INTERVAL_W-1:0];
			REG_MATCH_TOLERANCE:  tolerance  = value[INTERVAL_W-1:0];
			REG_SAMPLES_PER_TICK: tick_len   = value[SPT_W-1:0];
			REG_PATTERN_FIRST:    rhythm_lo  = value;
			REG_PATTERN_REST:     rhythm_hi  = value[55:0];
			default: ;
		endcase
	endtask

	// Zero, all ones or random within the register, sometimes with junk above it.
	function automatic logic [CFG_DATA_W-1:0] pick_setting(krm_reg_idx_t idx);
		int                    bits;
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] v;
		case (idx)
			REG_RISE_THRESHOLD:   bits = SAMPLE_W;
			REG_MIN_GAP_TICKS:    bits = INTERVAL_W;
			REG_MATCH_TOLERANCE:  bits = INTERVAL_W;
			REG_SAMPLES_PER_TICK: bits = SPT_W;
			REG_PATTERN_REST:     bits = 56;
			default:              bits = 64;
		endcase
		mask = (bits == 64) ? ALL_ONES : ((64'd1 << bits) - 64'd1);
		case ($urandom_range(3))
			0:       v = '0;
			1:       v = mask;
			default: v = {$urandom, $urandom} & mask;
		endcase
		if ($urandom_range(3) == 0)
			v = v | ({$urandom, $urandom} & ~mask);
		return v;
	endfunction

	// A sample that never rises, so it can never be taken for a knock.
	function automatic logic [SAMPLE_W-1:0] quiet_sample();
		return SAMPLE_W'($urandom_range(0, last_sample));
	endfunction

	// Waits out the ticks up to the wanted interval, then knocks.
	task automatic knock_after(input int target);
		if (target <= int'(gap_limit))
			target = int'(gap_limit) + 1;
		if (target > 255)
			target = 255;
		while (int'(ticks) < target || int'(last_sample) + int'(rise_limit) >= 1023)
			push_sample(quiet_sample());
		push_sample(SAMPLE_W'($urandom_range(int'(last_sample) + int'(rise_limit) + 1, 1023)));
	endtask

	// Result side: random back-pressure and the comparison.
	int hold_off = 0;

	always @(posedge clk) begin
		knock_result_t want;
		knock_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = knock_result_t'(m_tdata[9:0]);
				if (pending_results.size() == 0) begin
					$error("unexpected result item %h with no sample pending", m_tdata);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.knock_seen !== want.knock_seen) begin
						$error("knock_seen: expected %0d, got %0d", want.knock_seen,
							got.knock_seen);
						error_count++;
					end
					if (got.unlock !== want.unlock) begin
						$error("unlock: expected %0d, got %0d", want.unlock, got.unlock);
						error_count++;
					end
					if (got.knock_interval !== want.knock_interval) begin
						$error("knock_interval: expected %0d, got %0d", want.knock_interval,
							got.knock_interval);
						error_count++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				hold_off = idle_length() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int           random_start;
		int           phase;
		int           off_beat;
		int           jitter;
		int           tol;
		int           base;
		logic [119:0] beats;

		rise_limit  = RISE_THRESHOLD_RST;
		gap_limit   = MIN_GAP_TICKS_RST;
		tolerance   = MATCH_TOLERANCE_RST;
		tick_len    = SAMPLES_PER_TICK_RST;
		rhythm_lo   = PATTERN_FIRST_RST;
		rhythm_hi   = PATTERN_REST_RST;
		last_sample = '0;
		ticks       = '0;
		tick_phase  = '0;
		next_slot   = 0;
		foreach (intervals[i])
			intervals[i] = '0;

		// Reset values: no knock until the minimum gap has passed.
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1023, 1'b1, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b1, NO_KNOCK});
		// Lowest threshold and gap, one tick per sample; junk above each register.
		directed_rows.push_back('{ROW_WRITE, REG_RISE_THRESHOLD, 64'hFFFF_FFFF_FFFF_FC00,
			1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_MIN_GAP_TICKS, 64'hABCD_0000_0000_0F00,
			1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_SAMPLES_PER_TICK, 64'h0000_0000_0000_00C1,
			1'b0, NO_KNOCK});
		// The sample counter is already past the lowered tick length.
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b1, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1, 1'b1,
			'{knock_interval: 8'd1, unlock: 1'b0, knock_seen: 1'b1}});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1, 1'b1, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b1, NO_KNOCK});
		// Widest tolerance: any knock completes the rhythm.
		directed_rows.push_back('{ROW_WRITE, REG_MATCH_TOLERANCE, 64'd255, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1023, 1'b1,
			'{knock_interval: 8'd3, unlock: 1'b1, knock_seen: 1'b1}});
		// Largest gap can never be exceeded; a zero tick length counts as one.
		directed_rows.push_back('{ROW_WRITE, REG_MIN_GAP_TICKS, 64'd255, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_SAMPLES_PER_TICK, 64'd0, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b1, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1023, 1'b1, NO_KNOCK});
		// Largest threshold cannot be exceeded by a 10-bit rise; one less can.
		directed_rows.push_back('{ROW_WRITE, REG_MIN_GAP_TICKS, 64'd0, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_RISE_THRESHOLD, 64'd1023, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b1, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1023, 1'b1, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_RISE_THRESHOLD, 64'd1022, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b1, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1023, 1'b1,
			'{knock_interval: 8'd6, unlock: 1'b1, knock_seen: 1'b1}});
		// Zero tolerance against an all-ones pattern, slowest tick.
		directed_rows.push_back('{ROW_WRITE, REG_MATCH_TOLERANCE, 64'd0, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_PATTERN_FIRST, ALL_ONES, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_PATTERN_REST, ALL_ONES, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_SAMPLES_PER_TICK, 64'd63, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'h155, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'h2AA, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1023, 1'b0, NO_KNOCK});
		// Back to one tick per sample with the counter well past it, then a match.
		directed_rows.push_back('{ROW_WRITE, REG_SAMPLES_PER_TICK, 64'd1, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_WRITE, REG_MATCH_TOLERANCE, 64'd255, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd0, 1'b0, NO_KNOCK});
		directed_rows.push_back('{ROW_SAMPLE, REG_RISE_THRESHOLD, 64'd1023, 1'b0, NO_KNOCK});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_pct = 20;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				push_sample(directed_rows[i].value[SAMPLE_W-1:0], directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		random_start = items_sent;
		phase = 0;
		while (items_sent < random_start + 500) begin
			drain_results();
			case ($urandom_range(3))
				0:       gap_pct = 0;
				1:       gap_pct = 10;
				2:       gap_pct = 30;
				default: gap_pct = 60;
			endcase
			case ($urandom_range(3))
				0:       stall_pct = 0;
				1:       stall_pct = 10;
				2:       stall_pct = 30;
				default: stall_pct = 60;
			endcase

			if (phase == 1) begin
				// Long silence: the tick count must hold at its top value.
				write_reg(REG_RISE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
				write_reg(REG_MIN_GAP_TICKS, 64'd254);
				write_reg(REG_SAMPLES_PER_TICK, 64'd1);
				repeat (265) push_sample(quiet_sample());
				knock_after(255);
			end else if ($urandom_range(9) < 7) begin
				// Rhythm phase: short intervals so that a full ring fills quickly.
				base = $urandom_range(0, 2);
				tol  = $urandom_range(0, 3);
				for (int k = 0; k < PATTERN_LENGTH; k++)
					beats[8*k +: 8] = INTERVAL_W'(base + 1 + $urandom_range(0, 4));
				write_reg(REG_RISE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
				write_reg(REG_MIN_GAP_TICKS, CFG_DATA_W'(base));
				write_reg(REG_MATCH_TOLERANCE, CFG_DATA_W'(tol));
				write_reg(REG_SAMPLES_PER_TICK, ($urandom_range(4) == 0) ? 64'd2 : 64'd1);
				write_reg(REG_PATTERN_FIRST, beats[63:0]);
				write_reg(REG_PATTERN_REST, {8'h00, beats[119:64]});
				repeat ($urandom_range(1, 2)) begin
					// Now and then one beat lands just outside the tolerance.
					off_beat = ($urandom_range(3) == 0) ? $urandom_range(0, 14) : -1;
					for (int k = 0; k < PATTERN_LENGTH; k++) begin
						jitter = int'($urandom_range(0, 2 * tol)) - tol;
						if (k == off_beat)
							jitter = ($urandom_range(1) == 0) ? tol + 1 + $urandom_range(0, 2)
								: -(tol + 1 + $urandom_range(0, 2));
						knock_after(int'(rhythm_at(k)) + jitter);
					end
					repeat ($urandom_range(0, 5))
						push_sample(SAMPLE_W'($urandom_range(0, 1023)));
				end
			end else begin
				// Noise phase with extreme or random settings in every register.
				for (int r = 0; r <= int'(REG_PATTERN_REST); r++)
					write_reg(krm_reg_idx_t'(r), pick_setting(krm_reg_idx_t'(r)));
				repeat ($urandom_range(20, 40)) push_sample(SAMPLE_W'($urandom_range(0, 1023)));
			end
			phase++;
		end

		drain_results();
		repeat (3) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/krm_pkg.sv
rtl/krm_front.sv
rtl/krm_cell.sv
rtl/knock_rhythm_matcher.sv
tb/tb_knock_rhythm_matcher.sv
